// ===== rtl/chacha20_stream_cipher_assert.svh =====
// Assertion macros for the stream cipher; each expects clk and rst in scope.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CC20_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CC20_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cc20_pkg.sv =====
`timescale 1ns / 1ps
package cc20_pkg;

  localparam int DOUBLE_ROUNDS_DEF = 10;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [31:0] SIGMA [4] = '{
    32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_01   = 3'd0,
    CFG_KEY_23   = 3'd1,
    CFG_KEY_45   = 3'd2,
    CFG_KEY_67   = 3'd3,
    CFG_NONCE_01 = 3'd4,
    CFG_NONCE_2  = 3'd5,
    CFG_CTR_INIT = 3'd6
  } cfg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       take;    // capture the input transfer
    logic       load;    // load block input words
    logic       round;   // run one quarter-round step on all four lanes
    logic       diag;    // diagonal half of the double round
    logic [1:0] step;    // quarter-round step 0..3
    logic       finish;  // add input words back, leaving the keystream
    logic       emit;    // XOR the held byte into the output register
  } cc20_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic block_end;     // the held byte ends the message or the block
  } cc20_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

// ===== rtl/cc20_ctrl.sv =====
`timescale 1ns / 1ps
module cc20_ctrl #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic               m_axis_tready,
  output logic               m_axis_tvalid,
  input  cc20_pkg::cc20_stat_t stat,
  output cc20_pkg::cc20_cmd_t  cmd
);
  import cc20_pkg::*;

  localparam int RW = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  state_t          state, state_next;
  logic            pend;
  logic            ks_ready;
  logic [1:0]      step;
  logic            diag;
  logic [RW-1:0]   rnd;
  logic            out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !pend;

  always_comb begin
    cmd        = '0;
    cmd.take   = s_axis_tvalid && !pend;
    cmd.diag   = diag;
    cmd.step   = step;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pend && !ks_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_ROUND;
        end else if (pend && ks_ready && out_free) begin
          cmd.emit = 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (step == 2'd3 && diag && rnd == RW'(DOUBLE_ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pend          <= 1'b0;
      ks_ready      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      step          <= '0;
      diag          <= 1'b0;
      rnd           <= '0;
    end else begin
      state <= state_next;
      if (cmd.take) begin
        pend <= 1'b1;
      end else if (cmd.emit) begin
        pend <= 1'b0;
      end
      if (cmd.finish) begin
        ks_ready <= 1'b1;
      end else if (cmd.emit && stat.block_end) begin
        ks_ready <= 1'b0;
      end
      if (cmd.emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        step <= '0;
        diag <= 1'b0;
        rnd  <= '0;
      end else if (cmd.round) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          diag <= !diag;
          if (diag) begin
            rnd <= rnd + RW'(1);
          end
        end
      end
    end
  end

endmodule

// ===== rtl/cc20_datapath.sv =====
`timescale 1ns / 1ps
module cc20_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cc20_pkg::CFG_W-1:0]      cfg_data,
  input  logic [7:0]                      in_data,
  input  logic                            in_last,
  input  cc20_pkg::cc20_cmd_t             cmd,
  output cc20_pkg::cc20_stat_t            stat,
  output logic [7:0]                      out_data,
  output logic                            out_last
);
  import cc20_pkg::*;

  logic [63:0] key01, key23, key45, key67, nonce01;
  logic [31:0] nonce2, ctr_init;

  logic [31:0] w       [16];
  logic [31:0] w_round [16];
  logic [31:0] init    [16];
  logic [31:0] qa [4];
  logic [31:0] qb [4];
  logic [31:0] qc [4];
  logic [31:0] qd [4];

  logic [5:0]  pos;
  logic [31:0] offset;
  logic [7:0]  hold_data;
  logic        hold_last;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key01    <= '0;
      key23    <= '0;
      key45    <= '0;
      key67    <= '0;
      nonce01  <= '0;
      nonce2   <= '0;
      ctr_init <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_01:   key01    <= cfg_data;
        CFG_KEY_23:   key23    <= cfg_data;
        CFG_KEY_45:   key45    <= cfg_data;
        CFG_KEY_67:   key67    <= cfg_data;
        CFG_NONCE_01: nonce01  <= cfg_data;
        CFG_NONCE_2:  nonce2   <= cfg_data[31:0];
        CFG_CTR_INIT: ctr_init <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      init[j] = SIGMA[j];
    end
    init[4]  = key01[31:0];
    init[5]  = key01[63:32];
    init[6]  = key23[31:0];
    init[7]  = key23[63:32];
    init[8]  = key45[31:0];
    init[9]  = key45[63:32];
    init[10] = key67[31:0];
    init[11] = key67[63:32];
    init[12] = ctr_init + offset;
    init[13] = nonce01[31:0];
    init[14] = nonce01[63:32];
    init[15] = nonce2;
  end

  // Four quarter-round lanes, one add/xor/rotate step per cycle.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    logic [31:0] a, b, c, d, x, y, z, s, t, zs;
    logic        odd;
    assign odd = cmd.step[0];
    assign a   = w[i];
    assign b   = cmd.diag ? w[4 + ((i + 1) % 4)]  : w[4 + i];
    assign c   = cmd.diag ? w[8 + ((i + 2) % 4)]  : w[8 + i];
    assign d   = cmd.diag ? w[12 + ((i + 3) % 4)] : w[12 + i];
    assign x   = odd ? c : a;
    assign y   = odd ? d : b;
    assign z   = odd ? b : d;
    assign s   = x + y;
    assign zs  = z ^ s;
    always_comb begin
      case (cmd.step)
        2'd0:    t = rotl(zs, 16);
        2'd1:    t = rotl(zs, 12);
        2'd2:    t = rotl(zs, 8);
        default: t = rotl(zs, 7);
      endcase
    end
    assign qa[i] = odd ? a : s;
    assign qc[i] = odd ? s : c;
    assign qb[i] = odd ? t : b;
    assign qd[i] = odd ? d : t;
  end

  // Route lane results back to their word slots.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      w_round[j]      = qa[j];
      w_round[4 + j]  = cmd.diag ? qb[(j + 3) % 4] : qb[j];
      w_round[8 + j]  = cmd.diag ? qc[(j + 2) % 4] : qc[j];
      w_round[12 + j] = cmd.diag ? qd[(j + 1) % 4] : qd[j];
    end
  end

  // Working words; after the add-back they hold the keystream block.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 16; j++) begin
      if (cmd.load) begin
        w[j] <= init[j];
      end else if (cmd.round) begin
        w[j] <= w_round[j];
      end else if (cmd.finish) begin
        w[j] <= w[j] + init[j];
      end
    end
  end

  assign ks_word        = w[pos[5:2]];
  assign ks_byte        = 8'(ks_word >> {pos[1:0], 3'b000});
  assign stat.block_end = hold_last || (pos == 6'd63);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hold_data <= in_data;
      hold_last <= in_last;
    end
    if (cmd.emit) begin
      out_data <= hold_data ^ ks_byte;
      out_last <= hold_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      offset <= '0;
    end else if (cmd.emit) begin
      if (hold_last) begin
        pos    <= '0;
        offset <= '0;
      end else if (pos == 6'd63) begin
        pos    <= '0;
        offset <= offset + 32'd1;
      end else begin
        pos <= pos + 6'd1;
      end
    end
  end

endmodule

// ===== rtl/chacha20_stream_cipher.sv =====
// Each byte is captured in a hold register, then XORed with its keystream byte into the output
// register once that is free; a byte that starts a 64-byte block first waits while the block is
// generated. The next byte is taken only after the held byte is emitted. Blocks are generated
// by the four shared quarter-round lanes doing one add/xor/rotate step per cycle.
// Reset (rst, synchronous, active high) clears the configuration registers, counters and handshake state.
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_assert.svh"
module chacha20_stream_cipher #(
  parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration writes: index 0..6 selects key, nonce or initial counter.
  input  logic                           cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cc20_pkg::CFG_W-1:0]     cfg_data,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] data_in
  input  logic                           s_axis_tlast,   // last_in
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [7:0] data_out
  output logic                           m_axis_tlast    // last_out
);
  import cc20_pkg::*;

  cc20_cmd_t  cmd;
  cc20_stat_t stat;

  // Controller: holds one input transfer, runs the block generator on demand
  // and loads the output register once the keystream for the byte is there.
  cc20_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Datapath: configuration, working words, quarter-round lanes, byte counters.
  cc20_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // A block is only generated for a byte that is held and waiting.
  `CC20_ASSERT_SAME(a_load_pending, cmd.load, !s_axis_tready, "block start without pending byte")
  // No output transfer is loaded while rounds are running.
  `CC20_ASSERT_SAME(a_no_emit_round, cmd.round, !cmd.emit, "emit during rounds")
  // Never overwrite a result that has not been taken.
  `CC20_ASSERT_SAME(a_no_overwrite, cmd.emit, !m_axis_tvalid || m_axis_tready, "result lost")
  // A loaded result is shown on the next cycle.
  `CC20_ASSERT_NEXT(a_emit_valid, cmd.emit, m_axis_tvalid, "emit without valid")

endmodule
